// File: design/running_mean_variance_with_bins_core_assert.svh
// assertion macros for the running mean and variance core
`ifndef RUNNING_MEAN_VARIANCE_WITH_BINS_CORE_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_WITH_BINS_CORE_ASSERT_SVH

// same-cycle implication on the core clock
`define RMVB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the core clock
`define RMVB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rmvb_pkg.sv
// shared constants, types and helpers of the running mean and variance core
package rmvb_pkg;

    localparam int WORD_W     = 32;
    localparam int GUARD_BITS = 16;
    localparam int MEAN_W     = WORD_W + GUARD_BITS;
    localparam int DIFF_W     = MEAN_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = 63;
    localparam int SQ_SHIFT   = 32;
    localparam int STEP_W     = $clog2(DIFF_W + 1);
    localparam int TIME_SHIFT = DIFF_W - WORD_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_LENGTH = 1'd1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    localparam logic [WORD_W-1:0] BIN_LEN_RST = 32'd25600;
    localparam logic [WORD_W-1:0] WORD_MAX    = {WORD_W{1'b1}};
    localparam logic [SQ_W-1:0]   SQ_MAX      = {SQ_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] val);
        return (val == WORD_MAX) ? val : val + 1'b1;
    endfunction

    function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] val);
        return val[DIFF_W-1] ? (~val + 1'b1) : val;
    endfunction

endpackage

// File: design/rmvb_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module rmvb_div import rmvb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [STEP_W-1:0] i_len,
    input  logic [DIFF_W-1:0] i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output logic [DIFF_W-1:0] o_quot,
    output t_unit_stat        o_stat
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [DIFF_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;

    logic [WORD_W:0]   n_trial;
    logic [WORD_W:0]   n_diff;
    logic              n_ge;

    assign n_trial = {r_rem, r_quo[DIFF_W-1]};
    assign n_diff  = n_trial - {1'b0, r_dvs};
    assign n_ge    = (n_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[WORD_W-1:0] : n_trial[WORD_W-1:0];
            r_quo <= {r_quo[DIFF_W-2:0], n_ge};
        end
    end

    assign o_quot      = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: design/rmvb_mul.sv
// bit-serial shift-add multiplier with scaled, saturated result
module rmvb_mul import rmvb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIFF_W-1:0] i_a,
    input  logic [DIFF_W-1:0] i_b,
    output logic [SQ_W-1:0]   o_term,
    output t_unit_stat        o_stat
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIFF_W-1:0] r_a;
    logic [PROD_W-1:0] r_acc;

    logic [DIFF_W:0]   n_part;
    logic              n_sat;

    assign n_part = {1'b0, r_acc[PROD_W-1:DIFF_W]}
                  + (r_acc[0] ? {1'b0, r_a} : '0);
    assign n_sat  = |r_acc[PROD_W-1:SQ_W+SQ_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIFF_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= {{DIFF_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_acc <= {n_part, r_acc[DIFF_W-1:1]};
        end
    end

    assign o_term      = n_sat ? SQ_MAX : r_acc[SQ_W+SQ_SHIFT-1:SQ_SHIFT];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: design/running_mean_variance_with_bins_core.sv
// Online mean and variance core with optional per-interval bin means. Each
// transaction is one sample or one clear; every transaction gives exactly one
// result. A sample runs the bin steps only with binning on and a nonzero
// time stamp. The work is done by one shared radix-2 divider (for the mean
// step, the bin index and the bin mean step) and a bit-serial multiplier
// that runs alongside the bin index division. A result waits in the output
// register while the next transaction is already being worked on.
`include "running_mean_variance_with_bins_core_assert.svh"

module running_mean_variance_with_bins_core import rmvb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic signed [31:0]   i_sample_value,
    input  logic [31:0]          i_sample_time,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_sample_total,
    output logic signed [31:0]   o_mean_value,
    output logic [62:0]          o_squared_deviation_sum,
    output logic                 o_bin_closed,
    output logic signed [31:0]   o_bin_mean,
    output logic [31:0]          o_bin_index
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DIV_MEAN  = 3'd1;
    localparam logic [2:0] ST_MUL_START = 3'd2;
    localparam logic [2:0] ST_MUL       = 3'd3;
    localparam logic [2:0] ST_BIN_CHK   = 3'd4;
    localparam logic [2:0] ST_BIN_START = 3'd5;
    localparam logic [2:0] ST_BIN_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT       = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;

    logic              r_bin_en;
    logic [WORD_W-1:0] r_bin_len;

    logic [WORD_W-1:0] r_count;
    logic [MEAN_W-1:0] r_mean;
    logic [SQ_W-1:0]   r_sqsum;
    logic [WORD_W-1:0] r_last_bin;
    logic [WORD_W-1:0] r_bin_count;
    logic [MEAN_W-1:0] r_bin_mean;

    logic [MEAN_W-1:0] r_x;
    logic [WORD_W-1:0] r_t;
    logic [DIFF_W-1:0] r_dmag;
    logic              r_dneg;
    logic              r_bin_act;
    logic              r_closed;
    logic [WORD_W-1:0] r_cmean;
    logic [WORD_W-1:0] r_cidx;

    logic              r_o_valid;
    logic [WORD_W-1:0] r_o_total;
    logic [WORD_W-1:0] r_o_mean;
    logic [SQ_W-1:0]   r_o_sqsum;
    logic              r_o_bin_closed;
    logic [WORD_W-1:0] r_o_bin_mean;
    logic [WORD_W-1:0] r_o_bin_index;

    logic              n_accept;
    logic [MEAN_W-1:0] n_x;
    logic [WORD_W-1:0] n_cnt_inc;
    logic [WORD_W-1:0] n_bc_inc;
    logic [DIFF_W-1:0] n_d1;
    logic [DIFF_W-1:0] n_d2;
    logic [DIFF_W-1:0] n_db;
    logic [DIFF_W-1:0] n_qs;
    logic [DIFF_W-1:0] n_mean_sum;
    logic [DIFF_W-1:0] n_bmean_sum;
    logic [SQ_W:0]     n_sq_sum;
    logic              n_out_load;

    logic              div_start;
    logic [STEP_W-1:0] div_len;
    logic [DIFF_W-1:0] div_dividend;
    logic [WORD_W-1:0] div_divisor;
    logic [DIFF_W-1:0] div_quot;
    t_unit_stat        div_stat;

    logic              mul_start;
    logic [SQ_W-1:0]   mul_term;
    t_unit_stat        mul_stat;

    assign o_ready  = (r_state == ST_IDLE);
    assign n_accept = i_valid && o_ready;

    assign n_x        = {i_sample_value, {GUARD_BITS{1'b0}}};
    assign n_cnt_inc  = sat_inc(r_count);
    assign n_bc_inc   = sat_inc(r_bin_count);
    assign n_d1       = {n_x[MEAN_W-1], n_x} - {r_mean[MEAN_W-1], r_mean};
    assign n_d2       = {r_x[MEAN_W-1], r_x} - {r_mean[MEAN_W-1], r_mean};
    assign n_db       = {r_x[MEAN_W-1], r_x} - {r_bin_mean[MEAN_W-1], r_bin_mean};
    assign n_qs       = r_dneg ? (~div_quot + 1'b1) : div_quot;
    assign n_mean_sum  = {r_mean[MEAN_W-1], r_mean} + n_qs;
    assign n_bmean_sum = {r_bin_mean[MEAN_W-1], r_bin_mean} + n_qs;
    assign n_sq_sum   = {1'b0, r_sqsum} + {1'b0, mul_term};
    assign n_out_load = (r_state == ST_OUT) && (!r_o_valid || i_ready);

    // divider request by phase
    always_comb begin
        div_start    = 1'b0;
        div_len      = STEP_W'(DIFF_W);
        div_dividend = mag(n_d1);
        div_divisor  = n_cnt_inc;
        mul_start    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                div_start = n_accept && (i_kind == KIND_SAMPLE);
            end
            ST_MUL_START: begin
                div_start    = r_bin_en && (r_t != '0);
                div_len      = STEP_W'(WORD_W);
                div_dividend = {r_t, {TIME_SHIFT{1'b0}}};
                div_divisor  = r_bin_len;
                mul_start    = 1'b1;
            end
            ST_BIN_START: begin
                div_start    = 1'b1;
                div_dividend = mag(n_db);
                div_divisor  = n_bc_inc;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (n_accept) begin
                    n_state = (i_kind == KIND_CLEAR) ? ST_OUT : ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN: begin
                if (div_stat.done) begin
                    n_state = ST_MUL_START;
                end
            end
            ST_MUL_START: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    n_state = r_bin_act ? ST_BIN_CHK : ST_OUT;
                end
            end
            ST_BIN_CHK: begin
                n_state = ST_BIN_START;
            end
            ST_BIN_START: begin
                n_state = ST_BIN_DIV;
            end
            ST_BIN_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (n_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bin_en  <= 1'b0;
            r_bin_len <= BIN_LEN_RST;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BIN_ENABLE: r_bin_en  <= i_cfg_data[0];
                    CFG_BIN_LENGTH: r_bin_len <= i_cfg_data;
                    default: begin
                        r_bin_en <= r_bin_en;
                    end
                endcase
            end
            if (n_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mean      <= '0;
            r_sqsum     <= '0;
            r_last_bin  <= '0;
            r_bin_count <= '0;
            r_bin_mean  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        if (i_kind == KIND_CLEAR) begin
                            r_count     <= '0;
                            r_mean      <= '0;
                            r_sqsum     <= '0;
                            r_last_bin  <= '0;
                            r_bin_count <= '0;
                            r_bin_mean  <= '0;
                        end else begin
                            r_count <= n_cnt_inc;
                        end
                    end
                end
                ST_DIV_MEAN: begin
                    if (div_stat.done) begin
                        r_mean <= n_mean_sum[MEAN_W-1:0];
                    end
                end
                ST_MUL: begin
                    if (mul_stat.done) begin
                        r_sqsum <= n_sq_sum[SQ_W] ? SQ_MAX : n_sq_sum[SQ_W-1:0];
                    end
                end
                ST_BIN_CHK: begin
                    if (div_quot[WORD_W-1:0] > r_last_bin) begin
                        r_bin_count <= '0;
                        r_bin_mean  <= '0;
                        r_last_bin  <= div_quot[WORD_W-1:0];
                    end
                end
                ST_BIN_START: begin
                    r_bin_count <= n_bc_inc;
                end
                ST_BIN_DIV: begin
                    if (div_stat.done) begin
                        r_bin_mean <= n_bmean_sum[MEAN_W-1:0];
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // per-transaction working values
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (n_accept) begin
                    r_x      <= n_x;
                    r_t      <= i_sample_time;
                    r_dmag   <= mag(n_d1);
                    r_dneg   <= n_d1[DIFF_W-1];
                    r_closed <= 1'b0;
                    r_cmean  <= '0;
                    r_cidx   <= '0;
                end
            end
            ST_MUL_START: begin
                r_bin_act <= r_bin_en && (r_t != '0);
            end
            ST_BIN_CHK: begin
                if (div_quot[WORD_W-1:0] > r_last_bin) begin
                    r_closed <= 1'b1;
                    r_cmean  <= r_bin_mean[MEAN_W-1:GUARD_BITS];
                    r_cidx   <= r_last_bin;
                end
            end
            ST_BIN_START: begin
                r_dneg <= n_db[DIFF_W-1];
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_o_total      <= r_count;
            r_o_mean       <= r_mean[MEAN_W-1:GUARD_BITS];
            r_o_sqsum      <= r_sqsum;
            r_o_bin_closed <= r_closed;
            r_o_bin_mean   <= r_cmean;
            r_o_bin_index  <= r_cidx;
        end
    end

    rmvb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_len      (div_len),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    rmvb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_dmag),
        .i_b     (mag(n_d2)),
        .o_term  (mul_term),
        .o_stat  (mul_stat)
    );

    assign o_valid                 = r_o_valid;
    assign o_sample_total          = r_o_total;
    assign o_mean_value            = r_o_mean;
    assign o_squared_deviation_sum = r_o_sqsum;
    assign o_bin_closed            = r_o_bin_closed;
    assign o_bin_mean              = r_o_bin_mean;
    assign o_bin_index             = r_o_bin_index;

    `RMVB_ASSERT_NOW(a_div_idle, r_state == ST_IDLE, !div_stat.busy, "divider busy while idle")
    `RMVB_ASSERT_NOW(a_mul_phase, mul_stat.busy, r_state == ST_MUL,
        "multiplier busy out of phase")
    `RMVB_ASSERT_NEXT(a_count_hold, !n_accept, r_count == $past(r_count),
        "count moved without transaction")
    `RMVB_ASSERT_NOW(a_open_bin, r_o_valid && !r_o_bin_closed,
        r_o_bin_index == '0 && r_o_bin_mean == '0, "bin fields set without close")

endmodule

// File: tb/tb_running_mean_variance_with_bins_core.sv
// testbench for the running mean and variance core against a local predictor
module tb_running_mean_variance_with_bins_core import rmvb_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [31:0]        total;
        logic signed [31:0] mean;
        logic [SQ_W-1:0]    sqsum;
        logic               closed;
        logic signed [31:0] bin_mean;
        logic [31:0]        bin_idx;
    } t_stats_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_BIN_ENABLE;
    logic [WORD_W-1:0]    i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_kind = KIND_SAMPLE;
    logic signed [31:0]   i_sample_value = '0;
    logic [31:0]          i_sample_time = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [31:0]          o_sample_total;
    logic signed [31:0]   o_mean_value;
    logic [62:0]          o_squared_deviation_sum;
    logic                 o_bin_closed;
    logic signed [31:0]   o_bin_mean;
    logic [31:0]          o_bin_index;

    running_mean_variance_with_bins_core i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_kind                 (i_kind),
        .i_sample_value         (i_sample_value),
        .i_sample_time          (i_sample_time),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_sample_total         (o_sample_total),
        .o_mean_value           (o_mean_value),
        .o_squared_deviation_sum(o_squared_deviation_sum),
        .o_bin_closed           (o_bin_closed),
        .o_bin_mean             (o_bin_mean),
        .o_bin_index            (o_bin_index)
    );

    // predictor state
    logic               cfg_bin_on;
    logic [31:0]        cfg_bin_len;
    logic [31:0]        acc_count;
    logic signed [63:0] acc_mean;
    logic [SQ_W-1:0]    acc_sqsum;
    logic [31:0]        acc_last_bin;
    logic [31:0]        acc_bin_count;
    logic signed [63:0] acc_bin_mean;

    t_stats_result expected_stats[$];

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          items_sent = 0;
    int          clears_sent = 0;
    int          bins_closed_seen = 0;
    int unsigned cycle_count = 0;
    logic [31:0] stamp_clock = '0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results pending", cycle_count,
                         expected_stats.size());
                $display("running_mean_variance_with_bins_core regression: fail");
                $finish;
            end
        end
    end

    function automatic void clear_stats();
        acc_count     = '0;
        acc_mean      = '0;
        acc_sqsum     = '0;
        acc_last_bin  = '0;
        acc_bin_count = '0;
        acc_bin_mean  = '0;
    endfunction

    function automatic t_stats_result fold_into_stats(input logic kind,
                                                      input logic signed [31:0] value,
                                                      input logic [31:0] stamp);
        t_stats_result      res;
        logic signed [63:0] x;
        logic signed [63:0] d1;
        logic signed [63:0] d2;
        logic signed [63:0] db;
        logic signed [63:0] div;
        logic [63:0]        mag1;
        logic [63:0]        mag2;
        logic [127:0]       prod;
        logic [SQ_W-1:0]    term;
        logic [31:0]        idx;
        res = '0;
        if (kind == KIND_CLEAR) begin
            clear_stats();
        end else begin
            x = value;
            x = x * 65536;
            if (acc_count != WORD_MAX)
                acc_count = acc_count + 1;
            d1 = x - acc_mean;
            div = {32'b0, acc_count};
            acc_mean = acc_mean + d1 / div;
            d2 = x - acc_mean;
            mag1 = d1[63] ? -d1 : d1;
            mag2 = d2[63] ? -d2 : d2;
            prod = {64'b0, mag1} * {64'b0, mag2};
            term = (|prod[127:95]) ? SQ_MAX : prod[94:32];
            acc_sqsum = (term > SQ_MAX - acc_sqsum) ? SQ_MAX : acc_sqsum + term;
            if (cfg_bin_on && stamp != 0) begin
                idx = (cfg_bin_len != 0) ? stamp / cfg_bin_len : WORD_MAX;
                if (idx > acc_last_bin) begin
                    res.closed   = 1'b1;
                    res.bin_mean = acc_bin_mean[47:16];
                    res.bin_idx  = acc_last_bin;
                    acc_bin_count = '0;
                    acc_bin_mean  = '0;
                    acc_last_bin  = idx;
                end
                if (acc_bin_count != WORD_MAX)
                    acc_bin_count = acc_bin_count + 1;
                db = x - acc_bin_mean;
                div = {32'b0, acc_bin_count};
                acc_bin_mean = acc_bin_mean + db / div;
            end
        end
        res.total = acc_count;
        res.mean  = acc_mean[47:16];
        res.sqsum = acc_sqsum;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch in %s at result %0d: got %h, expected %h",
                     what, results_checked, got, want);
    endtask

    // result checker and receiver stalls
    initial begin
        t_stats_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_stats.size() == 0) begin
                    report_mismatch("transaction with nothing pending", 64'd0, 64'd0);
                end else begin
                    want = expected_stats.pop_front();
                    if (o_sample_total !== want.total)
                        report_mismatch("sample_total", o_sample_total, want.total);
                    if (o_mean_value !== want.mean)
                        report_mismatch("mean_value", o_mean_value, want.mean);
                    if (o_squared_deviation_sum !== want.sqsum)
                        report_mismatch("squared_deviation_sum", o_squared_deviation_sum,
                                        want.sqsum);
                    if (o_bin_closed !== want.closed)
                        report_mismatch("bin_closed", o_bin_closed, want.closed);
                    if (o_bin_mean !== want.bin_mean)
                        report_mismatch("bin_mean", o_bin_mean, want.bin_mean);
                    if (o_bin_index !== want.bin_idx)
                        report_mismatch("bin_index", o_bin_index, want.bin_idx);
                    if (want.closed)
                        bins_closed_seen++;
                end
                results_checked++;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic kind, input logic signed [31:0] value,
                             input logic [31:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_sample_value <= value;
        i_sample_time  <= stamp;
        do @(posedge i_clk); while (!o_ready);
        expected_stats.insert(expected_stats.size(), fold_into_stats(kind, value, stamp));
        items_sent++;
        if (kind == KIND_CLEAR)
            clears_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
    endtask

    // only called with nothing in flight
    task automatic program_binning(input logic enable, input logic [31:0] length,
                                   input bit length_too);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BIN_ENABLE;
        i_cfg_data  <= {31'b0, enable};
        @(posedge i_clk);
        cfg_bin_on = enable;
        if (length_too) begin
            i_cfg_index <= CFG_BIN_LENGTH;
            i_cfg_data  <= length;
            @(posedge i_clk);
            cfg_bin_len = length;
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] next_stamp();
        int          roll;
        logic [31:0] advance;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 15)
            return $urandom();
        if (cfg_bin_len == 0 || cfg_bin_len > 32'h0010_0000)
            advance = $urandom_range(0, 32'h0100_0000);
        else
            advance = $urandom_range(0, 2 * cfg_bin_len);
        stamp_clock = stamp_clock + advance;
        return stamp_clock;
    endfunction

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        if (roll < 80)
            return $urandom();
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            default: return 32'h0000_0000;
        endcase
    endfunction

    task automatic random_burst(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 5) begin
                stamp_clock = $urandom_range(0, 1000);
                send_item(KIND_CLEAR, $urandom(), $urandom());
            end else begin
                send_item(KIND_SAMPLE, pick_value(), next_stamp());
            end
        end
    endtask

    // binning off by default, so nonzero stamps must leave bins alone
    task automatic test_value_extremes();
        send_item(KIND_SAMPLE, 32'h0000_0000, 32'h0000_0000);
        send_item(KIND_SAMPLE, 32'h7FFF_FFFF, 32'd12345);
        send_item(KIND_SAMPLE, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0001);
        send_item(KIND_SAMPLE, 32'h8000_0000, 32'h0000_0000);
        send_item(KIND_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(KIND_CLEAR, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_SAMPLE, 32'h0000_0001, 32'h0000_0000);
        wait_drained();
    endtask

    task automatic test_default_bin_length();
        program_binning(1'b1, '0, 1'b0);
        send_item(KIND_SAMPLE, $urandom(), 32'd100);
        send_item(KIND_SAMPLE, $urandom(), 32'd25599);
        send_item(KIND_SAMPLE, $urandom(), 32'd25600);
        send_item(KIND_SAMPLE, $urandom(), 32'd0);
        send_item(KIND_SAMPLE, $urandom(), 32'd51200);
        send_item(KIND_SAMPLE, $urandom(), 32'd30000);
        wait_drained();
    endtask

    task automatic test_bin_length_extremes();
        program_binning(1'b1, 32'd1, 1'b1);
        send_item(KIND_CLEAR, '0, '0);
        send_item(KIND_SAMPLE, $urandom(), 32'd5);
        send_item(KIND_SAMPLE, $urandom(), 32'd6);
        send_item(KIND_SAMPLE, $urandom(), 32'd6);
        wait_drained();
        program_binning(1'b1, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_CLEAR, '0, '0);
        send_item(KIND_SAMPLE, $urandom(), 32'hFFFF_FFFE);
        send_item(KIND_SAMPLE, $urandom(), 32'hFFFF_FFFF);
        wait_drained();
        // zero length puts every nonzero stamp in the top bin
        program_binning(1'b1, 32'd0, 1'b1);
        send_item(KIND_CLEAR, '0, '0);
        send_item(KIND_SAMPLE, $urandom(), 32'd1);
        send_item(KIND_SAMPLE, $urandom(), 32'd2);
        send_item(KIND_SAMPLE, $urandom(), 32'd0);
        wait_drained();
    endtask

    task automatic test_back_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_binning(1'b1, 32'd300, 1'b1);
        stamp_clock = '0;
        hold_left = 1500;
        for (int n = 0; n < 16; n++)
            send_item(KIND_SAMPLE, pick_value(), next_stamp());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int idle_modes[4][2] = '{'{0, 0}, '{86, 0}, '{0, 86}, '{34, 34}};
        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct  = idle_modes[mode][0];
            recv_stall_pct = idle_modes[mode][1];
            for (int half = 0; half < 2; half++) begin
                case (mode * 2 + half)
                    0: program_binning(1'b1, $urandom_range(1, 4096), 1'b1);
                    1: program_binning(1'b0, $urandom(), 1'b1);
                    2: program_binning(1'b1, 32'd1, 1'b1);
                    3: program_binning(1'b1, $urandom_range(1, 4096), 1'b1);
                    4: program_binning(1'b1, 32'hFFFF_FFFF, 1'b1);
                    5: program_binning(1'b1, $urandom_range(256, 65536), 1'b1);
                    6: program_binning(1'b1, 32'd0, 1'b1);
                    default: program_binning(1'b1, $urandom_range(1, 4096), 1'b1);
                endcase
                stamp_clock = $urandom_range(0, 1000);
                random_burst(85);
                wait_drained();
            end
        end
    endtask

    initial begin
        cfg_bin_on  = 1'b0;
        cfg_bin_len = BIN_LEN_RST;
        clear_stats();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_value_extremes();
        test_default_bin_length();
        test_bin_length_extremes();
        test_back_pressure();
        test_random_traffic();

        repeat (200) @(posedge i_clk);
        $display("covered %0d transactions (%0d clears) under four idle patterns and a long stall",
                 items_sent, clears_sent);
        $display("checked %0d results, %0d of them closing a bin, %0d mismatches",
                 results_checked, bins_closed_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("running_mean_variance_with_bins_core regression: pass");
        end else begin
            $display("running_mean_variance_with_bins_core regression: fail");
        end
        $finish;
    end

endmodule
